FILE: sv/assert_macros.svh
// Assertion macros shared by the button click classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge, off while reset is asserted.
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Concurrent check on the rising edge, also during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/bcc_pkg.sv
// Types, codes and reset values for the button click classifier.
`timescale 1ns / 1ps

package bcc_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int REG_W           = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int EVENT_W         = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_ACTIVE_LEVEL = 2'd0;
    localparam cfg_idx_t CFG_DEBOUNCE     = 2'd1;
    localparam cfg_idx_t CFG_SINGLE_MAX   = 2'd2;
    localparam cfg_idx_t CFG_DOUBLE_GAP   = 2'd3;

    localparam logic             RST_ACTIVE_LEVEL = 1'b0;
    localparam logic [REG_W-1:0] RST_DEBOUNCE     = 16'd50;
    localparam logic [REG_W-1:0] RST_SINGLE_MAX   = 16'd1000;
    localparam logic [REG_W-1:0] RST_DOUBLE_GAP   = 16'd300;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HELD = 2'd1,
        PH_GAP  = 2'd2,
        PH_WAIT = 2'd3
    } phase_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } click_event_t;

    typedef struct packed {
        logic             active_level;
        logic [REG_W-1:0] debounce_ticks;
        logic [REG_W-1:0] single_max_ticks;
        logic [REG_W-1:0] double_gap_ticks;
    } cfg_t;

endpackage

FILE: sv/bcc_cfg_regs.sv
// Configuration register file of the button click classifier.
`timescale 1ns / 1ps

module bcc_cfg_regs
    import bcc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  cfg_idx_t         cfg_index,
    input  logic [REG_W-1:0] cfg_wdata,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_ACTIVE_LEVEL: cfg_next.active_level     = cfg_wdata[0];
                CFG_DEBOUNCE:     cfg_next.debounce_ticks   = cfg_wdata;
                CFG_SINGLE_MAX:   cfg_next.single_max_ticks = cfg_wdata;
                CFG_DOUBLE_GAP:   cfg_next.double_gap_ticks = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_level     <= RST_ACTIVE_LEVEL;
            cfg_reg.debounce_ticks   <= RST_DEBOUNCE;
            cfg_reg.single_max_ticks <= RST_SINGLE_MAX;
            cfg_reg.double_gap_ticks <= RST_DOUBLE_GAP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/bcc_fsm.sv
// Press / gap state machine with saturating tick counters.
`timescale 1ns / 1ps

module bcc_fsm
    import bcc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         sample_en,
    input  logic         pin_level,
    input  cfg_t         cfg,
    output click_event_t click_event
);

    `include "assert_macros.svh"

    localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] press_count_reg, press_count_next;
    logic [COUNT_WIDTH-1:0] gap_count_reg, gap_count_next;

    logic                   pressed;
    logic [COUNT_WIDTH-1:0] press_inc;
    logic [COUNT_WIDTH-1:0] gap_inc;
    logic [CMP_W-1:0]       press_ext;
    logic [CMP_W-1:0]       gap_inc_ext;
    logic                   gap_closed;
    logic                   above_debounce;
    logic                   above_single;

    assign pressed   = (pin_level == cfg.active_level);
    assign press_inc = (press_count_reg == CNT_MAX) ? CNT_MAX : press_count_reg + 1'b1;
    assign gap_inc   = (gap_count_reg == CNT_MAX) ? CNT_MAX : gap_count_reg + 1'b1;

    assign press_ext      = CMP_W'(press_count_reg);
    assign gap_inc_ext    = CMP_W'(gap_inc);
    assign gap_closed     = gap_inc_ext > CMP_W'(cfg.double_gap_ticks);
    assign above_debounce = press_ext > CMP_W'(cfg.debounce_ticks);
    assign above_single   = press_ext > CMP_W'(cfg.single_max_ticks);

    always_comb begin
        phase_next       = phase_reg;
        press_count_next = press_count_reg;
        gap_count_next   = gap_count_reg;
        click_event      = EV_NONE;
        unique case (phase_reg)
            PH_IDLE: begin
                if (pressed) begin
                    press_count_next = press_inc;
                    phase_next       = PH_HELD;
                end
            end
            PH_HELD, PH_GAP: begin
                if (pressed && phase_reg == PH_HELD) begin
                    press_count_next = press_inc;
                end else if (pressed) begin
                    // New press inside the window: double click, then wait for release
                    press_count_next = '0;
                    gap_count_next   = '0;
                    phase_next       = PH_WAIT;
                    click_event      = EV_DOUBLE;
                end else if (gap_closed) begin
                    // Window over: classify by press length, too short drops
                    press_count_next = '0;
                    gap_count_next   = '0;
                    phase_next       = PH_IDLE;
                    if (above_single) begin
                        click_event = EV_LONG;
                    end else if (above_debounce) begin
                        click_event = EV_SINGLE;
                    end
                end else begin
                    gap_count_next = gap_inc;
                    phase_next     = PH_GAP;
                end
            end
            PH_WAIT: begin
                if (!pressed) begin
                    press_count_next = '0;
                    gap_count_next   = '0;
                    phase_next       = PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            press_count_reg <= '0;
            gap_count_reg   <= '0;
        end else if (sample_en) begin
            phase_reg       <= phase_next;
            press_count_reg <= press_count_next;
            gap_count_reg   <= gap_count_next;
        end
    end

    `ASSERT_RST(a_gap_zero_outside_gap, aclk, aresetn, (phase_reg != PH_GAP) |-> (gap_count_reg == '0), "gap counter nonzero outside gap phase")
    `ASSERT_RST(a_idle_counts_clear, aclk, aresetn, (phase_reg == PH_IDLE || phase_reg == PH_WAIT) |-> (press_count_reg == '0), "press counter nonzero in idle or wait")
    `ASSERT_RST(a_double_then_wait, aclk, aresetn, (sample_en && click_event == EV_DOUBLE) |=> (phase_reg == PH_WAIT), "double click did not enter wait for release")

endmodule

FILE: sv/button_click_classifier.sv
// Top level of the push-button single / double / long click classifier.
//
//   channel   dir   handshake            payload
//   s_        in    s_tvalid/s_tready    s_tdata[0]   pin_level
//   m_        out   m_tvalid/m_tready    m_tdata[1:0] click_event
//   cfg_      in    cfg_we (no stall)    cfg_index, cfg_wdata
//
// One sample per cycle while s_tready is high: the state machine updates on the
// accepted transaction and the output register takes the event on the same edge.
// Every accepted sample yields exactly one result transaction (possibly none-event).
// Reset (aresetn low, synchronous) returns to idle with counters cleared and
// registers at their defaults.
// A stall on m_ holds the output register; s_tready drops only while a
// result waits and m_tready is low.
`timescale 1ns / 1ps

module button_click_classifier
    import bcc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic             aclk,
    input  logic             aresetn,
    // Sample channel
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [0] pin_level, [7:1] zero
    // Event channel
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [1:0] click_event, [7:2] zero
    // Configuration write port
    input  logic             cfg_we,
    input  cfg_idx_t         cfg_index,
    input  logic [REG_W-1:0] cfg_wdata
);

    `include "assert_macros.svh"

    cfg_t         cfg;
    click_event_t event_comb;
    logic         s_accept;

    logic         m_valid_reg, m_valid_next;
    click_event_t m_event_reg;

    bcc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bcc_fsm #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sample_en   (s_accept),
        .pin_level   (s_tdata[0]),
        .cfg         (cfg),
        .click_event (event_comb)
    );

    // Accept whenever the output register is empty or drains this cycle
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload: load on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_event_reg <= event_comb;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8 - EVENT_W){1'b0}}, m_event_reg};

    `ASSERT_RST(a_accept_gives_result, aclk, aresetn, s_accept |=> m_tvalid, "accepted sample produced no result")
    `ASSERT_ALWAYS(a_reset_clears_valid, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

FILE: bench/tb.sv
// Self-checking testbench for button_click_classifier: queued pin samples, per-tick prediction.
`timescale 1ns / 1ps

module tb;
    import bcc_pkg::*;

    localparam int CW = COUNT_WIDTH_DEF;

    // Clock and synchronous active-low reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #5 aclk = ~aclk;

    // DUT ports; every input starts at a known value
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = '0;    // [0] pin_level, [7:1] zero
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [7:0]       m_tdata;           // [1:0] click_event, [7:2] zero
    logic             cfg_we    = 1'b0;
    cfg_idx_t         cfg_index = CFG_ACTIVE_LEVEL;
    logic [REG_W-1:0] cfg_wdata = '0;

    button_click_classifier u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Pin samples waiting to be sent, and click events still owed by the DUT
    logic         pin_queue[$];
    click_event_t events_due[$];

    int   idle_pct       = 18;   // chance in a hundred that a side idles this cycle
    int   mismatch_count = 0;
    logic s_taken        = 1'b0; // the sample on s_tdata was accepted at the last rising edge

    // Shadow of the configuration registers
    logic             lvl_q;
    logic [REG_W-1:0] debounce_q;
    logic [REG_W-1:0] single_max_q;
    logic [REG_W-1:0] double_gap_q;

    // Shadow of the classifier state
    phase_t           ph_q;
    logic [CW-1:0]    press_cnt;
    logic [CW-1:0]    gap_cnt;

    // Press length latched before the counters clear, so the class uses the old count.
    logic [CW-1:0] press_cnt_at_close;

    function automatic logic [CW-1:0] bump(input logic [CW-1:0] v);
        return (v == {CW{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic void clear_to_idle();
        ph_q      = PH_IDLE;
        press_cnt = '0;
        gap_cnt   = '0;
    endfunction

    // One released tick with the gap open: classify once the window has passed.
    function automatic click_event_t count_gap_tick();
        gap_cnt = bump(gap_cnt);
        if (gap_cnt > double_gap_q) begin
            clear_to_idle();
            if (press_cnt_at_close > debounce_q && press_cnt_at_close <= single_max_q) begin
                return EV_SINGLE;
            end
            if (press_cnt_at_close > single_max_q) begin
                return EV_LONG;
            end
        end
        return EV_NONE;
    endfunction

    // Advance the shadow state by one accepted pin sample and return the expected event.
    function automatic click_event_t next_event(input logic pin);
        logic         pressed;
        click_event_t ev;
        pressed            = (pin == lvl_q);
        ev                 = EV_NONE;
        press_cnt_at_close = press_cnt;
        case (ph_q)
            PH_IDLE: begin
                if (pressed) begin
                    press_cnt = bump(press_cnt);
                    ph_q      = PH_HELD;
                end
            end
            PH_HELD: begin
                if (pressed) begin
                    press_cnt = bump(press_cnt);
                end else begin
                    // the first released tick already counts as gap tick one
                    ph_q = PH_GAP;
                    ev   = count_gap_tick();
                end
            end
            PH_GAP: begin
                if (pressed) begin
                    // press inside the window: double click, then wait for release
                    press_cnt = '0;
                    gap_cnt   = '0;
                    ph_q      = PH_WAIT;
                    ev        = EV_DOUBLE;
                end else begin
                    ev = count_gap_tick();
                end
            end
            default: begin
                if (!pressed) begin
                    clear_to_idle();
                end
            end
        endcase
        return ev;
    endfunction

    // Monitor: sample everything at the rising edge, predict on input transactions,
    // check on output transactions.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_taken      <= 1'b0;
            lvl_q        = RST_ACTIVE_LEVEL;
            debounce_q   = RST_DEBOUNCE;
            single_max_q = RST_SINGLE_MAX;
            double_gap_q = RST_DOUBLE_GAP;
            clear_to_idle();
        end else begin
            s_taken <= s_tvalid && s_tready;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ACTIVE_LEVEL: lvl_q        = cfg_wdata[0];
                    CFG_DEBOUNCE:     debounce_q   = cfg_wdata;
                    CFG_SINGLE_MAX:   single_max_q = cfg_wdata;
                    default:          double_gap_q = cfg_wdata;
                endcase
            end
            if (s_tvalid && s_tready) begin
                events_due.push_back(next_event(s_tdata[0]));
            end
            if (m_tvalid && m_tready) begin
                if (events_due.size() == 0) begin
                    $error("click_event: transaction with nothing expected, got %0d",
                           m_tdata[EVENT_W-1:0]);
                    mismatch_count++;
                end else begin
                    click_event_t want;
                    want = events_due.pop_front();
                    if (m_tdata[EVENT_W-1:0] !== want) begin
                        $error("click_event: expected %0d, got %0d",
                               want, m_tdata[EVENT_W-1:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[7:EVENT_W] !== '0) begin
                        $error("m_tdata padding: expected 0, got %0h", m_tdata[7:EVENT_W]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Driver: hold the current sample until taken, then advance or idle at random.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (pin_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {7'b0, pin_queue.pop_front()};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // Queue n samples that read as pressed (or released) under active level lvl.
    task automatic queue_run(input logic lvl, input logic pressed, input int n);
        for (int i = 0; i < n; i++) begin
            pin_queue.push_back(pressed ? lvl : ~lvl);
        end
    endtask

    // Drive the four registers back to back, then drop the write enable.
    task automatic set_config(input logic act, input logic [REG_W-1:0] deb,
                              input logic [REG_W-1:0] smax, input logic [REG_W-1:0] gap);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ACTIVE_LEVEL;
        cfg_wdata <= REG_W'(act);
        @(negedge aclk);
        cfg_index <= CFG_DEBOUNCE;
        cfg_wdata <= deb;
        @(negedge aclk);
        cfg_index <= CFG_SINGLE_MAX;
        cfg_wdata <= smax;
        @(negedge aclk);
        cfg_index <= CFG_DOUBLE_GAP;
        cfg_wdata <= gap;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Hold off until every sample is sent and every event has come back.
    task automatic wait_idle();
        while (pin_queue.size() != 0 || s_tvalid || events_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (2) @(negedge aclk);
    endtask

    // Mostly press/release pairs sized around the thresholds, some random pin noise.
    task automatic fill_random(input logic lvl, input int deb, input int smax,
                               input int gap, input int n);
        int np_hi;
        int np;
        int ng;
        np_hi = (smax > deb) ? smax : deb;
        if (np_hi > 20) begin
            np_hi = 20;
        end
        while (pin_queue.size() < n) begin
            if ($urandom_range(99) < 85) begin
                np = $urandom_range(1, np_hi + 3);
                ng = $urandom_range(1, ((gap > 20) ? 20 : gap) + 2);
                queue_run(lvl, 1'b1, np);
                queue_run(lvl, 1'b0, ng);
            end else begin
                ng = $urandom_range(1, 6);
                for (int i = 0; i < ng; i++) begin
                    pin_queue.push_back(logic'($urandom_range(1)));
                end
            end
        end
    endtask

    initial begin : stimulus
        logic             act;
        logic [REG_W-1:0] deb;
        logic [REG_W-1:0] smax;
        logic [REG_W-1:0] gap;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset defaults, active low: press, short release, press again inside the
        // window for a double click, stay pressed (ignored), release back to idle.
        pin_queue = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
        wait_idle();

        // Active high, tight thresholds: single, long, too-short press, idle release
        set_config(1'b1, 16'd1, 16'd3, 16'd1);
        queue_run(1'b1, 1'b1, 2);
        queue_run(1'b1, 1'b0, 2);
        queue_run(1'b1, 1'b1, 5);
        queue_run(1'b1, 1'b0, 2);
        queue_run(1'b1, 1'b1, 1);
        queue_run(1'b1, 1'b0, 3);
        wait_idle();

        // Long run with no idling on either side.
        idle_pct = 0;
        set_config(1'b0, 16'd2, 16'd6, 16'd3);
        fill_random(1'b0, 2, 6, 3, 120);
        wait_idle();
        idle_pct = 18;

        // Random phases over small thresholds; the first two use the extremes
        // (zero everywhere) and a single limit below the debounce time.
        for (int p = 0; p < 8; p++) begin
            act  = logic'($urandom_range(1));
            deb  = REG_W'($urandom_range(4));
            smax = REG_W'($urandom_range(8));
            gap  = REG_W'($urandom_range(5));
            if (p == 0) begin
                deb  = '0;
                smax = '0;
                gap  = '0;
            end else if (p == 1) begin
                deb  = 16'd6;
                smax = 16'd2;
            end
            set_config(act, deb, smax, gap);
            fill_random(act, int'(deb), int'(smax), int'(gap), 135);
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Watchdog: well past the slowest legal run
    initial begin
        #10_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
